>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cda check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cda check failed");

`endif

>>> rtl/cda_pkg.sv
package cda_pkg;

    localparam int ACTION_W = 2;
    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMOUNT_W = 12;

    localparam int AMOUNT_BITS_DEFAULT = 12;
    localparam int YEAR_BITS_DEFAULT   = 16;

    localparam int YEAR_RESET      = 2000;
    localparam int MONTH_MIN       = 1;
    localparam int MONTH_MAX       = 12;
    localparam int MONTHS_PER_YEAR = 12;
    localparam int MONTH_FEB       = 2;
    localparam int FEB_LEAP_DAYS   = 29;
    localparam int LONG_MONTH_DAYS = 31;
    localparam int LEAP_CYCLE      = 400;
    localparam int CENTURY         = 100;
    localparam int REM400_W        = $clog2(LEAP_CYCLE);

    // day sum and month total never exceed 31 + max amount
    localparam int DSUM_W  = AMOUNT_W + 1;
    localparam int TOTAL_W = AMOUNT_W + 1;

    // divide by 12: floor(t * 682 / 2^13) is t/12 or one less for t < 2^13
    localparam int RECIP12       = 682;
    localparam int RECIP_W       = 10;
    localparam int RECIP12_SHIFT = 13;
    localparam int PROD_W        = TOTAL_W + RECIP_W;
    localparam int QUOT_W        = PROD_W - RECIP12_SHIFT;

    // year mod 400 = 16 * ((year >> 4) mod 25) + year[3:0], year up to 32 bits
    // floor(t * RECIP25 / 2^32) is t/25 or one less for t < 2^28
    localparam int MOD_EXT_W     = 32;
    localparam int MOD_LOW_BITS  = 4;
    localparam int LOW_MOD       = LEAP_CYCLE >> MOD_LOW_BITS;
    localparam int RECIP25       = 171798691;
    localparam int RECIP25_SHIFT = 32;
    localparam int MOD_STEPS     = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DAY_W-1:0] MONTH_LEN [0:12] =
        '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET        = 2'd0,
        ACT_ADD_DAYS   = 2'd1,
        ACT_ADD_MONTHS = 2'd2,
        ACT_ADD_YEARS  = 2'd3
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [YEAR_W-1:0]   new_year;
        logic [MONTH_W-1:0]  new_month;
        logic [DAY_W-1:0]    new_day;
        logic [AMOUNT_W-1:0] amount;
    } req_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [DAY_W-1:0]   cur_day;
        logic               year_wrapped;
    } res_item_t;

    // classified command as it waits between front and back
    typedef struct packed {
        action_t             action;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [AMOUNT_W-1:0] amount;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DAYS,
        B_MDIV,
        B_MFIX,
        B_YADD,
        B_MOD,
        B_CLAMP,
        B_OUT
    } back_state_t;

    function automatic logic is_leap(input logic [REM400_W-1:0] rem);
        logic leap;
        leap = (rem[1:0] == 2'd0)
            && (rem != REM400_W'(CENTURY))
            && (rem != REM400_W'(2 * CENTURY))
            && (rem != REM400_W'(3 * CENTURY));
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_W'(MONTH_FEB) && leap)
            len = DAY_W'(FEB_LEAP_DAYS);
        else if (month < MONTH_W'(MONTH_MIN) || month > MONTH_W'(MONTH_MAX))
            len = DAY_W'(LONG_MONTH_DAYS);
        else
            len = MONTH_LEN[month];
        return len;
    endfunction

endpackage

>>> rtl/cda_fifo.sv
module cda_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  cda_pkg::cmd_t wr_data,
    output logic          full,
    output logic          rd_valid,
    output cda_pkg::cmd_t rd_data,
    input  logic          rd_en
);

    localparam int DEPTH = cda_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cda_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/cda_front.sv
module cda_front #(
    parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cda_pkg::req_item_t request,
    output logic               full,
    output logic               cmd_valid,
    output cda_pkg::cmd_t      cmd,
    input  logic               cmd_pop
);

    cda_pkg::cmd_t            cmd_in;
    logic [AMOUNT_BITS-1:0]   amount_cut;

    // month clamped on the way in, amount cut to the configured width
    always_comb
    begin
        amount_cut    = AMOUNT_BITS'(request.amount);
        cmd_in.action = cda_pkg::action_t'(request.action);
        cmd_in.year   = request.new_year;
        cmd_in.day    = request.new_day;
        cmd_in.amount = cda_pkg::AMOUNT_W'(amount_cut);
        if (request.new_month < cda_pkg::MONTH_W'(cda_pkg::MONTH_MIN))
            cmd_in.month = cda_pkg::MONTH_W'(cda_pkg::MONTH_MIN);
        else if (request.new_month > cda_pkg::MONTH_W'(cda_pkg::MONTH_MAX))
            cmd_in.month = cda_pkg::MONTH_W'(cda_pkg::MONTH_MAX);
        else
            cmd_in.month = request.new_month;
    end

    cda_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (cmd_in),
        .full     (full),
        .rd_valid (cmd_valid),
        .rd_data  (cmd),
        .rd_en    (cmd_pop)
    );

endmodule

>>> rtl/cda_mod400.sv
module cda_mod400 #(
    parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [YEAR_BITS-1:0]         value,
    output logic                         busy,
    output logic [cda_pkg::REM400_W-1:0] rem
);

    localparam int REM_W  = cda_pkg::REM400_W;
    localparam int EXT_W  = cda_pkg::MOD_EXT_W;
    localparam int LOW_W  = cda_pkg::MOD_LOW_BITS;
    localparam int HI_W   = EXT_W - LOW_W;
    localparam int MP_W   = 2 * HI_W;
    localparam int QE_W   = MP_W - cda_pkg::RECIP25_SHIFT;
    localparam int STEP_W = $clog2(cda_pkg::MOD_STEPS + 1);

    logic [EXT_W-1:0]  val_reg, val_next;
    logic [MP_W-1:0]   prod_reg, prod_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [HI_W-1:0]   hi;
    logic [QE_W-1:0]   q_est;
    logic [HI_W-1:0]   r_est;
    logic [HI_W-1:0]   r_fix;

    assign busy  = (step_reg != '0);
    assign rem   = rem_reg;
    assign hi    = val_reg[EXT_W-1:LOW_W];
    assign q_est = prod_reg[MP_W-1:cda_pkg::RECIP25_SHIFT];
    // hi - 25 * q_est, shifts only; one subtract brings it below 25
    assign r_est = hi - HI_W'({q_est, 4'b0000}) - HI_W'({q_est, 3'b000}) - HI_W'(q_est);
    assign r_fix = (r_est >= HI_W'(cda_pkg::LOW_MOD)) ? r_est - HI_W'(cda_pkg::LOW_MOD)
                                                      : r_est;

    always_comb
    begin
        val_next  = val_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (start)
        begin
            val_next  = EXT_W'(value);
            step_next = STEP_W'(cda_pkg::MOD_STEPS);
        end
        else if (step_reg == STEP_W'(cda_pkg::MOD_STEPS))
        begin
            prod_next = MP_W'(hi) * MP_W'(cda_pkg::RECIP25);
            step_next = step_reg - 1'b1;
        end
        else if (busy)
        begin
            rem_next  = {r_fix[REM_W-LOW_W-1:0], val_reg[LOW_W-1:0]};
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

endmodule

>>> rtl/cda_back.sv
module cda_back #(
    parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cda_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    output cda_pkg::res_item_t res,
    input  logic               res_pop
);

    localparam int MONTH_W = cda_pkg::MONTH_W;
    localparam int DAY_W   = cda_pkg::DAY_W;
    localparam int REM_W   = cda_pkg::REM400_W;
    localparam int DSUM_W  = cda_pkg::DSUM_W;
    localparam int TOTAL_W = cda_pkg::TOTAL_W;
    localparam int PROD_W  = cda_pkg::PROD_W;
    localparam int QUOT_W  = cda_pkg::QUOT_W;
    localparam int AMT_W   = cda_pkg::AMOUNT_W;

    cda_pkg::back_state_t state_reg, state_next;

    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 wrap_reg, wrap_next;
    logic [DSUM_W-1:0]    dsum_reg, dsum_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [AMT_W-1:0]     addend_reg, addend_next;
    logic                 res_valid_reg, res_valid_next;
    cda_pkg::res_item_t   res_reg, res_next;

    logic                 mod_start;
    logic [YEAR_BITS-1:0] mod_value;
    logic                 mod_busy;
    logic [REM_W-1:0]     mod_rem;

    logic                 leap;
    logic [DAY_W-1:0]     len;
    logic [DSUM_W-1:0]    len_ext;
    logic                 days_fit;
    logic [YEAR_BITS:0]   year_inc;
    logic [YEAR_BITS:0]   year_sum;
    logic [QUOT_W-1:0]    q_est;
    logic [TOTAL_W-1:0]   r_est;
    logic                 r_over;
    logic                 res_free;

    assign leap     = cda_pkg::is_leap(rem_reg);
    assign len      = cda_pkg::days_in(month_reg, leap);
    assign len_ext  = DSUM_W'(len);
    assign days_fit = (dsum_reg <= len_ext);
    assign year_inc = {1'b0, year_reg} + (YEAR_BITS + 1)'(1);
    assign year_sum = {1'b0, year_reg} + (YEAR_BITS + 1)'(addend_reg);
    assign q_est    = prod_reg[PROD_W-1:cda_pkg::RECIP12_SHIFT];
    // total - 12 * q_est, shifts only
    assign r_est    = total_reg - TOTAL_W'({q_est, 3'b000}) - TOTAL_W'({q_est, 2'b00});
    assign r_over   = (r_est >= TOTAL_W'(cda_pkg::MONTHS_PER_YEAR));
    assign res_free = !res_valid_reg || res_pop;

    assign cmd_pop   = (state_reg == cda_pkg::B_IDLE) && cmd_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    cda_mod400 #(
        .YEAR_BITS (YEAR_BITS)
    ) u_mod400 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (mod_value),
        .busy  (mod_busy),
        .rem   (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cda_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.action)
                        cda_pkg::ACT_SET:        state_next = cda_pkg::B_MOD;
                        cda_pkg::ACT_ADD_DAYS:   state_next = cda_pkg::B_DAYS;
                        cda_pkg::ACT_ADD_MONTHS: state_next = cda_pkg::B_MDIV;
                        default:                 state_next = cda_pkg::B_YADD;
                    endcase
                end
            end
            cda_pkg::B_DAYS:
            begin
                if (days_fit)
                    state_next = cda_pkg::B_OUT;
            end
            cda_pkg::B_MDIV:  state_next = cda_pkg::B_MFIX;
            cda_pkg::B_MFIX:  state_next = cda_pkg::B_YADD;
            cda_pkg::B_YADD:  state_next = cda_pkg::B_MOD;
            cda_pkg::B_MOD:
            begin
                if (!mod_busy)
                    state_next = cda_pkg::B_CLAMP;
            end
            cda_pkg::B_CLAMP: state_next = cda_pkg::B_OUT;
            cda_pkg::B_OUT:
            begin
                if (res_free)
                    state_next = cda_pkg::B_IDLE;
            end
            default:          state_next = cda_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        rem_next       = rem_reg;
        wrap_next      = wrap_reg;
        dsum_next      = dsum_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        addend_next    = addend_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;
        mod_start      = 1'b0;
        mod_value      = year_sum[YEAR_BITS-1:0];

        unique case (state_reg)
            cda_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    wrap_next   = 1'b0;
                    dsum_next   = DSUM_W'(day_reg) + DSUM_W'(cmd.amount);
                    total_next  = TOTAL_W'(month_reg) - TOTAL_W'(cda_pkg::MONTH_MIN)
                                + TOTAL_W'(cmd.amount);
                    addend_next = cmd.amount;
                    if (cmd.action == cda_pkg::ACT_SET)
                    begin
                        year_next  = YEAR_BITS'(cmd.year);
                        month_next = cmd.month;
                        day_next   = cmd.day;
                        mod_start  = 1'b1;
                        mod_value  = YEAR_BITS'(cmd.year);
                    end
                end
            end
            cda_pkg::B_DAYS:
            begin
                // one month walked per cycle
                if (days_fit)
                begin
                    day_next = DAY_W'(dsum_reg);
                end
                else
                begin
                    dsum_next = dsum_reg - len_ext;
                    if (month_reg == MONTH_W'(cda_pkg::MONTH_MAX))
                    begin
                        month_next = MONTH_W'(cda_pkg::MONTH_MIN);
                        year_next  = year_inc[YEAR_BITS-1:0];
                        if (year_inc[YEAR_BITS])
                        begin
                            wrap_next = 1'b1;
                            rem_next  = '0;
                        end
                        else if (rem_reg == REM_W'(cda_pkg::LEAP_CYCLE - 1))
                            rem_next = '0;
                        else
                            rem_next = rem_reg + 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
            end
            cda_pkg::B_MDIV:
            begin
                prod_next = PROD_W'(total_reg) * PROD_W'(cda_pkg::RECIP12);
            end
            cda_pkg::B_MFIX:
            begin
                if (r_over)
                begin
                    addend_next = AMT_W'(q_est) + 1'b1;
                    month_next  = MONTH_W'(r_est - TOTAL_W'(cda_pkg::MONTHS_PER_YEAR))
                                + MONTH_W'(cda_pkg::MONTH_MIN);
                end
                else
                begin
                    addend_next = AMT_W'(q_est);
                    month_next  = MONTH_W'(r_est) + MONTH_W'(cda_pkg::MONTH_MIN);
                end
            end
            cda_pkg::B_YADD:
            begin
                year_next = year_sum[YEAR_BITS-1:0];
                wrap_next = wrap_reg || year_sum[YEAR_BITS];
                mod_start = 1'b1;
            end
            cda_pkg::B_MOD:
            begin
                if (!mod_busy)
                    rem_next = mod_rem;
            end
            cda_pkg::B_CLAMP:
            begin
                if (day_reg > len)
                    day_next = len;
                else if (day_reg == '0)
                    day_next = DAY_W'(1);
            end
            cda_pkg::B_OUT:
            begin
                if (res_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next.cur_year     = cda_pkg::YEAR_W'(year_reg);
                    res_next.cur_month    = month_reg;
                    res_next.cur_day      = day_reg;
                    res_next.year_wrapped = wrap_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cda_pkg::B_IDLE;
            year_reg      <= YEAR_BITS'(cda_pkg::YEAR_RESET);
            month_reg     <= MONTH_W'(cda_pkg::MONTH_MIN);
            day_reg       <= DAY_W'(1);
            rem_reg       <= REM_W'(cda_pkg::YEAR_RESET % cda_pkg::LEAP_CYCLE);
            wrap_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            rem_reg       <= rem_next;
            wrap_reg      <= wrap_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsum_reg   <= dsum_next;
        total_reg  <= total_next;
        prod_reg   <= prod_next;
        addend_reg <= addend_next;
        res_reg    <= res_next;
    end

endmodule

>>> rtl/calendar_date_adder.sv
// channel   dir  handshake              payload
// request   in   push, taken when !full  cda_pkg::req_item_t
// result    out  pop, offered when !empty cda_pkg::res_item_t
//
// one item at a time in the back end; up to two items wait in the front queue
// set date passes the mod-400 unit and the day clamp; add years first adds the years,
// then does the same; add months divides by 12 before that; the mod-400 unit uses a
// reciprocal multiply and one fix-up; add days walks one month at a time instead
// reset loads 2000-01-01; a waiting result holds while pop is low, and the
// front keeps taking items until its queue is full
`include "assert_macros.svh"

module calendar_date_adder #(
    parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEFAULT,
    parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cda_pkg::req_item_t request,
    output logic               empty,
    input  logic               pop,
    output cda_pkg::res_item_t result
);

    logic          cmd_valid;
    logic          cmd_pop;
    cda_pkg::cmd_t cmd;
    logic          res_valid;

    assign empty = !res_valid;

    cda_front #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cda_back #(
        .YEAR_BITS (YEAR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (result),
        .res_pop   (pop)
    );

    `CDA_ASSERT_NOW(a_month_range, !empty, (result.cur_month >= 4'd1) && (result.cur_month <= 4'd12))
    `CDA_ASSERT_NOW(a_day_nonzero, !empty, result.cur_day != 5'd0)
    `CDA_ASSERT_NEXT(a_push_queued, push && !full, cmd_valid)

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import cda_pkg::*;

    localparam int YEAR_BITS   = YEAR_BITS_DEFAULT;
    localparam int AMOUNT_BITS = AMOUNT_BITS_DEFAULT;
    localparam int RANDOM_REQS = 1725;
    localparam int DRAIN_CYCLES = 200;
    localparam longint unsigned YEAR_TOP = (64'd1 << YEAR_BITS) - 1;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    req_item_t request = '0;
    logic      empty;
    logic      pop = 1'b0;
    res_item_t result;

    req_item_t pending_reqs[$];
    res_item_t expected_dates[$];

    // calendar state tracked alongside the block
    longint unsigned cal_year;
    int unsigned     cal_month;
    int unsigned     cal_day;

    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   req_wait = 0;
    int   res_wait = 0;
    bit   req_burst = 1'b0;
    bit   res_burst = 1'b0;

    int err_count = 0;
    int results_checked = 0;
    int wraps_seen = 0;
    int action_count[4] = '{0, 0, 0, 0};

    calendar_date_adder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit leap_year(input longint unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_days(input longint unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:            len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  len = 30;
            default:      len = 31;
        endcase
        return len;
    endfunction

    // returns 1 when the year runs past its top
    function automatic bit bump_year(input longint unsigned n);
        longint unsigned sum;
        sum = cal_year + n;
        cal_year = sum & YEAR_TOP;
        return sum > YEAR_TOP;
    endfunction

    function automatic void clamp_day();
        int unsigned len;
        len = month_days(cal_year, cal_month);
        if (cal_day > len)
            cal_day = len;
        if (cal_day < 1)
            cal_day = 1;
    endfunction

    task automatic advance_date(input req_item_t req, output res_item_t date);
        longint unsigned amt;
        longint unsigned total;
        longint unsigned d;
        int unsigned     m;
        bit              wrapped;
        amt = req.amount & ((64'd1 << AMOUNT_BITS) - 1);
        wrapped = 1'b0;
        case (action_t'(req.action))
            ACT_SET:
            begin
                m = 32'(req.new_month);
                if (m < 1)
                    m = 1;
                if (m > 12)
                    m = 12;
                cal_year = req.new_year & YEAR_TOP;
                cal_month = m;
                cal_day = 32'(req.new_day);
                clamp_day();
            end
            ACT_ADD_DAYS:
            begin
                d = cal_day + amt;
                while (d > month_days(cal_year, cal_month))
                begin
                    d -= month_days(cal_year, cal_month);
                    cal_month++;
                    if (cal_month > 12)
                    begin
                        cal_month = 1;
                        if (bump_year(1))
                            wrapped = 1'b1;
                    end
                end
                cal_day = 32'(d);
            end
            ACT_ADD_MONTHS:
            begin
                total = (cal_month - 1) + amt;
                if (bump_year(total / 12))
                    wrapped = 1'b1;
                cal_month = 32'((total % 12) + 1);
                clamp_day();
            end
            default:
            begin
                if (bump_year(amt))
                    wrapped = 1'b1;
                clamp_day();
            end
        endcase
        date.cur_year = cal_year[YEAR_W-1:0];
        date.cur_month = cal_month[MONTH_W-1:0];
        date.cur_day = cal_day[DAY_W-1:0];
        date.year_wrapped = wrapped;
    endtask

    // wait before the next item; now and then flip into or out of a no-idle stretch
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 49) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic queue_req(input action_t act, input int y, input int m, input int d,
                             input int amt);
        req_item_t req;
        req.action = act;
        req.new_year = y[YEAR_W-1:0];
        req.new_month = m[MONTH_W-1:0];
        req.new_day = d[DAY_W-1:0];
        req.amount = amt[AMOUNT_W-1:0];
        pending_reqs.push_back(req);
    endtask

    function automatic req_item_t random_request();
        req_item_t req;
        int        pick;
        int        yr_choice[6];
        yr_choice = '{1900, 2000, 2100, 2400, 0, 65535};
        req.new_year = YEAR_W'($urandom_range(0, 65535));
        req.new_month = MONTH_W'($urandom_range(0, 15));
        req.new_day = DAY_W'($urandom_range(0, 31));
        req.amount = AMOUNT_W'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            req.action = ACT_SET;
            case ($urandom_range(0, 3))
                0: req.new_year = YEAR_W'($urandom_range(65400, 65535));
                1: req.new_year = YEAR_W'(yr_choice[$urandom_range(0, 5)]
                                          + $urandom_range(0, 1));
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0)
                req.new_month = MONTH_W'($urandom_range(1, 12));
        end
        else
        begin
            if (pick < 55)
                req.action = ACT_ADD_DAYS;
            else if (pick < 80)
                req.action = ACT_ADD_MONTHS;
            else
                req.action = ACT_ADD_YEARS;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: req.amount = AMOUNT_W'($urandom_range(0, 40));
                4, 5, 6:    req.amount = AMOUNT_W'($urandom_range(0, 400));
                7, 8:       ;
                default:    req.amount = AMOUNT_W'($urandom_range(0, 1) ? 4095 : 0);
            endcase
        end
        return req;
    endfunction

    // driver: request and pop change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pop <= 1'b0;
        end
        else
        begin
            if (req_taken)
            begin
                void'(pending_reqs.pop_front());
                req_wait = draw_wait(req_burst);
            end
            if (!push || req_taken)
            begin
                if (req_wait > 0)
                begin
                    req_wait--;
                    push <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    push <= 1'b1;
                    request <= pending_reqs[0];
                end
                else
                    push <= 1'b0;
            end

            if (res_taken)
                res_wait = draw_wait(res_burst);
            if (res_wait > 0)
            begin
                pop <= 1'b0;
                if (!empty)
                    res_wait--;
            end
            else
                pop <= 1'b1;
        end
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin : monitor
        res_item_t want;
        if (rst_n)
        begin
            req_taken <= push && !full;
            res_taken <= pop && !empty;
            if (push && !full)
            begin
                action_count[request.action]++;
                advance_date(request, want);
                expected_dates.push_back(want);
            end
            if (pop && !empty)
            begin
                results_checked++;
                if (expected_dates.size() == 0)
                begin
                    $error("result with no item waiting: %0d-%0d-%0d wrap %0b",
                           result.cur_year, result.cur_month, result.cur_day,
                           result.year_wrapped);
                    err_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (want.year_wrapped)
                        wraps_seen++;
                    if (result.cur_year !== want.cur_year)
                    begin
                        $error("cur_year expected %0d actual %0d", want.cur_year,
                               result.cur_year);
                        err_count++;
                    end
                    if (result.cur_month !== want.cur_month)
                    begin
                        $error("cur_month expected %0d actual %0d", want.cur_month,
                               result.cur_month);
                        err_count++;
                    end
                    if (result.cur_day !== want.cur_day)
                    begin
                        $error("cur_day expected %0d actual %0d", want.cur_day,
                               result.cur_day);
                        err_count++;
                    end
                    if (result.year_wrapped !== want.year_wrapped)
                    begin
                        $error("year_wrapped expected %0b actual %0b", want.year_wrapped,
                               result.year_wrapped);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        cal_year = YEAR_RESET;
        cal_month = 1;
        cal_day = 1;

        // add zero from the reset date, then leap, century and clamp corners
        queue_req(ACT_ADD_DAYS, 0, 0, 0, 0);
        queue_req(ACT_SET, 2000, 2, 29, 0);
        queue_req(ACT_ADD_YEARS, 0, 0, 0, 1);
        queue_req(ACT_SET, 1900, 2, 29, 0);
        queue_req(ACT_SET, 2024, 2, 31, 0);
        queue_req(ACT_SET, 0, 2, 29, 0);
        queue_req(ACT_SET, 2023, 0, 0, 0);
        queue_req(ACT_SET, 2023, 15, 31, 0);
        queue_req(ACT_SET, 2023, 13, 5, 0);
        queue_req(ACT_SET, 2023, 4, 31, 0);
        queue_req(ACT_ADD_MONTHS, 0, 0, 0, 0);
        queue_req(ACT_ADD_YEARS, 0, 0, 0, 0);
        queue_req(ACT_SET, 2024, 1, 31, 0);
        queue_req(ACT_ADD_MONTHS, 0, 0, 0, 1);
        queue_req(ACT_SET, 2100, 1, 31, 0);
        queue_req(ACT_ADD_MONTHS, 0, 0, 0, 1);
        // year top: wrap by days, months and years
        queue_req(ACT_SET, 65535, 12, 31, 0);
        queue_req(ACT_ADD_DAYS, 0, 0, 0, 1);
        queue_req(ACT_SET, 65535, 12, 1, 0);
        queue_req(ACT_ADD_MONTHS, 0, 0, 0, 4095);
        queue_req(ACT_SET, 65000, 2, 29, 0);
        queue_req(ACT_ADD_YEARS, 0, 0, 0, 4095);
        queue_req(ACT_SET, 1999, 12, 31, 0);
        queue_req(ACT_ADD_DAYS, 65535, 15, 31, 4095);
        queue_req(ACT_ADD_YEARS, 65535, 15, 31, 4095);

        repeat (RANDOM_REQS)
            pending_reqs.push_back(random_request());

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !push);
        wait (expected_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_dates.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_dates.size());
            err_count++;
        end
        $display("covered %0d sets, %0d day adds, %0d month adds, %0d year adds",
                 action_count[ACT_SET], action_count[ACT_ADD_DAYS],
                 action_count[ACT_ADD_MONTHS], action_count[ACT_ADD_YEARS]);
        $display("%0d results checked, %0d with year wrap, %0d mismatches",
                 results_checked, wraps_seen, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d items unsent and %0d results outstanding",
                 pending_reqs.size(), expected_dates.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
